// File: hdl/fdr_pkg.sv
// Package for the Fresnel dielectric reflectance pipeline.
// Holds the pipeline item type and stage map; no dependencies.
`default_nettype none
package fdr_pkg;

  localparam int CosW  = 18;
  localparam int EtaW  = 16;
  localparam int ReflW = 17;
  localparam int CW    = 17;
  localparam int RemW  = 35;
  localparam int DenW  = 34;

  localparam logic [CW-1:0] OneQ16 = CW'(65536);

  // stage map
  localparam int SRad1  = 0;
  localparam int SSqrt1 = 1;   // 17 steps
  localparam int SMulX  = 18;
  localparam int SDiv   = 19;  // 16 steps
  localparam int SRad2  = 35;
  localparam int SSqrt2 = 36;  // 17 steps
  localparam int SProd  = 53;
  localparam int SDiff  = 54;
  localparam int SRatio = 55;  // 17 steps
  localparam int SSq    = 72;
  localparam int SSum   = 73;
  localparam int NumStages = 74;

  typedef struct packed {
    logic [EtaW-1:0] ei;
    logic [EtaW-1:0] et;
    logic [CW-1:0]   c;
    logic            tir;
    logic [RemW-1:0] ra;
    logic [RemW-1:0] rb;
    logic [DenW-1:0] ma;
    logic [DenW-1:0] mb;
    logic [CW-1:0]   qa;
    logic [CW-1:0]   qb;
  } item_t;

endpackage
`default_nettype wire

// File: hdl/fdr_if.sv
// Stream interfaces for the reflectance block: input and result channels.
// Depends on fdr_pkg for field widths.
`default_nettype none
interface fdr_in_if
  import fdr_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic signed [CosW-1:0] cos_incident;
  logic [EtaW-1:0]        eta_incident;
  logic [EtaW-1:0]        eta_transmit;

  modport source (output valid, cos_incident, eta_incident, eta_transmit, input ready);
  modport sink   (input valid, cos_incident, eta_incident, eta_transmit, output ready);
endinterface

interface fdr_out_if
  import fdr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ReflW-1:0]  reflectance;
  logic              total_internal;

  modport source (output valid, reflectance, total_internal, input ready);
  modport sink   (input valid, reflectance, total_internal, output ready);
endinterface
`default_nettype wire

// File: hdl/fresnel_dielectric_reflectance.sv
// Fresnel dielectric reflectance: top level, the whole 74-stage pipeline.
// Depends on fdr_pkg and the stream interfaces in fdr_if.sv.
`default_nettype none
// Takes one transaction per cycle while not stalled; the pipeline length is set
// by the bit-per-stage square roots (17 stages each), the Snell divider (16
// stages) and the two ratio dividers (17 stages, in parallel). The pipeline
// stalls as a whole only when its last stage holds a result that the sink
// does not take; no transaction is lost or repeated.
module fresnel_dielectric_reflectance
  import fdr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  fdr_in_if.sink      sample,
  fdr_out_if.source   result
);

  function automatic item_t step(input int k, input item_t d);
    item_t           o;
    int              b;
    logic [DenW-1:0] prod;
    logic [RemW-1:0] trial;
    logic [RemW-1:0] r;
    logic [DenW-1:0] pa, qa2, pb, qb2;
    logic [CW-1:0]   fa, fb;
    logic [RemW:0]   sum;
    logic [18:0]     refl;
    o = d;
    if (k == SRad1) begin
      prod = DenW'(d.c) * DenW'(d.c);
      o.ra = RemW'(64'h1_0000_0000) - RemW'(prod);
      o.qa = '0;
    end else if (k >= SSqrt1 && k < SMulX) begin
      b = 16 - (k - SSqrt1);
      trial = (RemW'(d.qa) << (b + 1)) + (RemW'(1) << (2 * b));
      if (d.ra >= trial) begin
        o.ra = d.ra - trial;
        o.qa = d.qa | (CW'(1) << b);
      end
    end else if (k == SMulX) begin
      o.ra  = RemW'(DenW'(d.ei) * DenW'(d.qa));
      o.tir = (RemW'(DenW'(d.ei) * DenW'(d.qa)) >= (RemW'(d.et) << 16));
      o.qa  = '0;
    end else if (k >= SDiv && k < SRad2) begin
      b = 15 - (k - SDiv);
      trial = RemW'(d.et) << b;
      if (d.ra >= trial) begin
        o.ra = d.ra - trial;
        o.qa = d.qa | (CW'(1) << b);
      end
    end else if (k == SRad2) begin
      prod = DenW'(d.qa) * DenW'(d.qa);
      o.ra = RemW'(64'h1_0000_0000) - RemW'(prod);
      o.qa = '0;
    end else if (k >= SSqrt2 && k < SProd) begin
      b = 16 - (k - SSqrt2);
      trial = (RemW'(d.qa) << (b + 1)) + (RemW'(1) << (2 * b));
      if (d.ra >= trial) begin
        o.ra = d.ra - trial;
        o.qa = d.qa | (CW'(1) << b);
      end
    end else if (k == SProd) begin
      // parallel: et*c vs ei*cosT; perpendicular: ei*c vs et*cosT
      o.ra = RemW'(DenW'(d.et) * DenW'(d.c));
      o.ma = DenW'(d.ei) * DenW'(d.qa);
      o.rb = RemW'(DenW'(d.ei) * DenW'(d.c));
      o.mb = DenW'(d.et) * DenW'(d.qa);
    end else if (k == SDiff) begin
      pa  = DenW'(d.ra);
      qa2 = d.ma;
      pb  = DenW'(d.rb);
      qb2 = d.mb;
      o.ra = RemW'((pa >= qa2) ? (pa - qa2) : (qa2 - pa));
      o.ma = pa + qa2;
      o.rb = RemW'((pb >= qb2) ? (pb - qb2) : (qb2 - pb));
      o.mb = pb + qb2;
      o.qa = '0;
      o.qb = '0;
    end else if (k >= SRatio && k < SSq) begin
      // restoring division of diff<<16 by den, remainder kept below 2*den
      b = 16 - (k - SRatio);
      r = (b == 16) ? d.ra : (d.ra << 1);
      if (r >= RemW'(d.ma)) begin
        r = r - RemW'(d.ma);
        o.qa = d.qa | (CW'(1) << b);
      end
      o.ra = r;
      r = (b == 16) ? d.rb : (d.rb << 1);
      if (r >= RemW'(d.mb)) begin
        r = r - RemW'(d.mb);
        o.qb = d.qb | (CW'(1) << b);
      end
      o.rb = r;
    end else if (k == SSq) begin
      fa = (d.ma == '0) ? OneQ16 : d.qa;
      fb = (d.mb == '0) ? OneQ16 : d.qb;
      o.ra = RemW'(DenW'(fa) * DenW'(fa));
      o.rb = RemW'(DenW'(fb) * DenW'(fb));
    end else begin
      sum  = (RemW+1)'(d.ra) + (RemW+1)'(d.rb) + (RemW+1)'(65536);
      refl = 19'(sum >> 17);
      if (d.tir || refl > 19'(OneQ16))
        o.qa = OneQ16;
      else
        o.qa = refl[CW-1:0];
    end
    return o;
  endfunction

  item_t                  pipe [NumStages];
  logic [NumStages-1:0]   vld;
  item_t                  nxt  [NumStages];
  item_t                  head;
  logic                   adv;

  logic signed [CosW-1:0] cs;
  logic signed [CosW-1:0] clamped;
  logic signed [CosW-1:0] mag;
  logic                   neg;

  assign adv          = !vld[NumStages-1] || result.ready;
  assign sample.ready = adv;

  always_comb begin
    cs = sample.cos_incident;
    if (cs > CosW'(65536))
      clamped = CosW'(65536);
    else if (cs < -CosW'(65536))
      clamped = -CosW'(65536);
    else
      clamped = cs;
    neg = clamped < 0;
    mag = neg ? -clamped : clamped;
    head     = '0;
    head.c   = mag[CW-1:0];
    head.ei  = neg ? sample.eta_transmit : sample.eta_incident;
    head.et  = neg ? sample.eta_incident : sample.eta_transmit;
  end

  assign nxt[0] = step(0, head);

  for (genvar k = 1; k < NumStages; k++) begin : g_stage
    assign nxt[k] = step(k, pipe[k-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NumStages-2:0], sample.valid};
    end
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        pipe[k] <= nxt[k];
      end
    end
  end

  assign result.valid          = vld[NumStages-1];
  assign result.reflectance    = pipe[NumStages-1].qa;
  assign result.total_internal = pipe[NumStages-1].tir;

endmodule
`default_nettype wire

// File: tb/fresnel_dielectric_reflectance_test.sv
// Self-checking testbench for the Fresnel dielectric reflectance pipeline.
// Depends on fdr_pkg and the stream interfaces in fdr_if.sv; computes the
// expected reflectance in integer arithmetic and checks every transaction.
`default_nettype none
module fresnel_dielectric_reflectance_test;
  import fdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ReflW-1:0] refl;
    logic             tir;
  } refl_t;

  localparam int WatchdogLimit = 2000;

  logic clk;
  logic rst;
  fdr_in_if  sample();
  fdr_out_if result();

  fresnel_dielectric_reflectance u_top (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source)
  );

  refl_t expected_q[$];
  int n_sent;
  int n_checked;
  int n_tir;
  int n_mismatch;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned amplitude(longint unsigned p, longint unsigned q);
    longint unsigned den;
    longint unsigned diff;
    den = p + q;
    diff = (p >= q) ? p - q : q - p;
    if (den == 0) return 65536;
    return (diff << 16) / den;
  endfunction

  function automatic refl_t fresnel(logic signed [CosW-1:0] cs_in,
                                    logic [EtaW-1:0] eta_i, logic [EtaW-1:0] eta_t);
    refl_t r;
    longint cs;
    longint unsigned ei, et, c, sin_i, x, sin_t, cos_t, rpar, rperp, sum, refl;
    cs = cs_in;
    ei = eta_i;
    et = eta_t;
    if (cs > 65536) cs = 65536;
    if (cs < -65536) cs = -65536;
    if (cs < 0) begin
      ei = eta_t;
      et = eta_i;
      c = -cs;
    end else begin
      c = cs;
    end
    sin_i = int_sqrt((64'd1 << 32) - c * c);
    x = ei * sin_i;
    if (x >= et * 65536) begin
      r.refl = 17'd65536;
      r.tir = 1'b1;
      return r;
    end
    sin_t = x / et;
    cos_t = int_sqrt((64'd1 << 32) - sin_t * sin_t);
    rpar = amplitude(et * c, ei * cos_t);
    rperp = amplitude(ei * c, et * cos_t);
    sum = rpar * rpar + rperp * rperp;
    refl = (sum + (64'd1 << 16)) >> 17;
    if (refl > 65536) refl = 65536;
    r.refl = refl[ReflW-1:0];
    r.tir = 1'b0;
    return r;
  endfunction

  // one transaction, with a random gap before it
  task automatic send(logic signed [CosW-1:0] cs, logic [EtaW-1:0] ei, logic [EtaW-1:0] et);
    int gap;
    gap = $urandom_range(3);
    if (gap != 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample.valid <= 1'b1;
    sample.cos_incident <= cs;
    sample.eta_incident <= ei;
    sample.eta_transmit <= et;
    @(posedge clk);
    while (!sample.ready) @(posedge clk);
    expected_q.push_back(fresnel(cs, ei, et));
    n_sent++;
  endtask

  task automatic idle_input();
    sample.valid <= 1'b0;
  endtask

  task automatic test_extremes();
    send(18'sd65536, 16'h1000, 16'h1000);
    send(-18'sd65536, 16'h1000, 16'h1800);
    send(18'sd0, 16'h1000, 16'h1800);
    send(18'sd0, 16'h1800, 16'h1000);
    send(18'sd131071, 16'h1555, 16'h1000);
    send(-18'sd131072, 16'h1000, 16'h1555);
    send(18'sd70000, 16'hFFFF, 16'h0001);
    send(-18'sd70000, 16'h0001, 16'hFFFF);
    send(18'sd1, 16'hFFFF, 16'hFFFF);
    send(-18'sd1, 16'h0001, 16'h0001);
    send(18'sd32768, 16'h0000, 16'h1000);  // zero incident index
    send(18'sd0, 16'h0000, 16'h1000);      // zero ratio denominator
    send(18'sd40000, 16'h1000, 16'h0000);  // zero transmitted index
    send(-18'sd40000, 16'h0000, 16'h1000); // swapped to zero transmitted
    send(18'sd0, 16'h0000, 16'h0000);
    send(18'sd46341, 16'h1800, 16'h1000);  // near critical angle
    send(18'sd65535, 16'hAAAA, 16'h5555);
    send(-18'sd65535, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_random();
    int kind;
    logic signed [CosW-1:0] cs;
    logic [EtaW-1:0] ei, et;
    for (int i = 0; i < 1030; i++) begin
      kind = $urandom_range(9);
      if (kind < 6) begin
        // physical angle and glass-like indices
        cs = CosW'($signed($urandom_range(131072)) - 65536);
        ei = 16'($urandom_range(16'h3000, 16'h1000));
        et = 16'($urandom_range(16'h3000, 16'h1000));
      end else if (kind < 8) begin
        cs = CosW'($signed($urandom_range(131072)) - 65536);
        ei = 16'($urandom);
        et = 16'($urandom);
      end else begin
        cs = 18'($urandom);
        ei = 16'($urandom);
        et = (kind == 9) ? 16'($urandom_range(3)) : 16'($urandom);
      end
      send(cs, ei, et);
    end
  endtask

  // result side: random wait before each transaction, compare in order
  initial begin
    int stall;
    refl_t e;
    result.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = $urandom_range(3);
      if (stall != 0) begin
        result.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result.ready <= 1'b1;
      @(posedge clk);
      while (!result.valid) @(posedge clk);
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transaction: refl=%0d tir=%0b",
                   result.reflectance, result.total_internal);
      end else begin
        e = expected_q.pop_front();
        n_checked++;
        if (e.tir) n_tir++;
        if (result.reflectance !== e.refl || result.total_internal !== e.tir) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch #%0d: refl exp %0d got %0d, tir exp %0b got %0b",
                     n_checked, e.refl, result.reflectance, e.tir,
                     result.total_internal);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  initial begin
    idle_cycles = 0;
    timed_out = 1'b0;
    forever begin
      @(posedge clk);
      if ((sample.valid && sample.ready) || (result.valid && result.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit && !timed_out) begin
        timed_out = 1'b1;
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst <= 1'b1;
    sample.valid <= 1'b0;
    sample.cos_incident <= '0;
    sample.eta_incident <= '0;
    sample.eta_transmit <= '0;
    n_sent = 0;
    n_checked = 0;
    n_tir = 0;
    n_mismatch = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_random();
    idle_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (NumStages + 10) @(posedge clk);
    $display("sent %0d transactions, checked %0d results (%0d total internal)",
             n_sent, n_checked, n_tir);
    if (n_mismatch == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hdl/fdr_pkg.sv
hdl/fdr_if.sv
hdl/fresnel_dielectric_reflectance.sv
tb/fresnel_dielectric_reflectance_test.sv
